// ===== design/usdrh_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// USB standard device request handler - shared types and constants
// Request, response and device context types, plus the request, recipient
// and descriptor codes used by the decoder and the top level.
// -----------------------------------------------------------------------------
package usdrh_pkg;

   typedef enum logic [2:0] {
      RSP_STALL = 3'd0,
      RSP_ACK   = 3'd1,
      RSP_DATA  = 3'd2,
      RSP_ITF   = 3'd3,
      RSP_EP    = 3'd4,
      RSP_FETCH = 3'd5,
      RSP_NONE  = 3'd6
   } rsp_code_type;

   typedef enum logic [1:0] {
      DEV_DEFAULT    = 2'd0,
      DEV_ADDRESSED  = 2'd1,
      DEV_CONFIGURED = 2'd2
   } dev_state_code_type;

   typedef enum logic [1:0] {
      CLS_NONE      = 2'd0,
      CLS_SET       = 2'd1,
      CLS_CLEAR     = 2'd2,
      CLS_CLEAR_SET = 2'd3
   } class_act_type;

   // Standard request codes
   localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
   localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
   localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
   localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
   localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
   localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
   localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

   // Recipient field, bits 4:0 of the request type byte
   localparam logic [4:0] RCP_DEVICE    = 5'd0;
   localparam logic [4:0] RCP_INTERFACE = 5'd1;
   localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

   localparam logic [15:0] FEATURE_REMOTE_WAKEUP = 16'd1;

   localparam logic [7:0] DESC_DEVICE       = 8'd1;
   localparam logic [7:0] DESC_CONFIGURATION = 8'd2;
   localparam logic [7:0] DESC_STRING       = 8'd3;
   localparam logic [7:0] DESC_STRING_MAX   = 8'd5;

   // Configuration register indexes
   localparam logic CSR_MAX_CONFIGURATIONS = 1'b0;
   localparam logic CSR_SELF_POWERED       = 1'b1;

   localparam logic [7:0] MAX_CONFIGURATIONS_RESET = 8'd1;

   typedef struct packed {
      logic        func;
      logic [7:0]  bm_request;
      logic [7:0]  b_request;
      logic [15:0] w_value;
      logic [15:0] w_index;
      logic [15:0] w_length;
   } req_item_type;

   typedef struct packed {
      rsp_code_type       response;
      logic [15:0]        reply_value;
      logic [15:0]        reply_length;
      class_act_type      class_action;
      logic [7:0]         class_config;
      logic [6:0]         device_address;
      dev_state_code_type device_state;
   } rsp_item_type;

   typedef struct packed {
      dev_state_code_type state;
      logic [6:0]         address;
      logic [7:0]         cfg;
      logic               wakeup;
   } dev_ctx_type;

endpackage
`default_nettype wire

// ===== design/usdrh_decode.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// USB standard device request handler - request decoder
// Decides the response to one item and the device context that follows it.
// -----------------------------------------------------------------------------
module usdrh_decode (
   input  usdrh_pkg::req_item_type req,
   input  usdrh_pkg::dev_ctx_type  ctx,
   input  logic [7:0]              max_configurations,
   input  logic                    self_powered,
   output usdrh_pkg::rsp_item_type rsp,
   output usdrh_pkg::dev_ctx_type  ctx_next
);

   always_comb begin
      logic       live;
      logic [7:0] idx;
      logic [7:0] desc_type;
      logic       desc_ok;

      live      = (ctx.state == usdrh_pkg::DEV_ADDRESSED) ||
                  (ctx.state == usdrh_pkg::DEV_CONFIGURED);
      idx       = req.w_value[7:0];
      desc_type = req.w_value[15:8];
      desc_ok   = (desc_type == usdrh_pkg::DESC_DEVICE) ||
                  (desc_type == usdrh_pkg::DESC_CONFIGURATION) ||
                  ((desc_type == usdrh_pkg::DESC_STRING) &&
                   (idx <= usdrh_pkg::DESC_STRING_MAX));

      ctx_next         = ctx;
      rsp.response     = usdrh_pkg::RSP_STALL;
      rsp.reply_value  = '0;
      rsp.reply_length = '0;
      rsp.class_action = usdrh_pkg::CLS_NONE;
      rsp.class_config = '0;

      if (req.func) begin
         // Disconnect keeps address, configuration and wakeup flag.
         ctx_next.state   = usdrh_pkg::DEV_DEFAULT;
         rsp.class_action = usdrh_pkg::CLS_CLEAR;
         rsp.class_config = ctx.cfg;
         rsp.response     = usdrh_pkg::RSP_NONE;
      end else begin
         case (req.bm_request[4:0])
            usdrh_pkg::RCP_DEVICE: begin
               case (req.b_request)
                  usdrh_pkg::REQ_GET_STATUS: begin
                     if (live) begin
                        rsp.reply_value  = {14'd0, ctx.wakeup, self_powered};
                        rsp.reply_length = 16'd2;
                        rsp.response     = usdrh_pkg::RSP_DATA;
                     end
                  end
                  usdrh_pkg::REQ_CLEAR_FEATURE: begin
                     if (live) begin
                        if (req.w_value == usdrh_pkg::FEATURE_REMOTE_WAKEUP) begin
                           ctx_next.wakeup = 1'b0;
                           rsp.response    = usdrh_pkg::RSP_ACK;
                        end else begin
                           rsp.response = usdrh_pkg::RSP_NONE;
                        end
                     end
                  end
                  usdrh_pkg::REQ_SET_FEATURE: begin
                     if (req.w_value == usdrh_pkg::FEATURE_REMOTE_WAKEUP) begin
                        ctx_next.wakeup = 1'b1;
                        rsp.response    = usdrh_pkg::RSP_ACK;
                     end else begin
                        rsp.response = usdrh_pkg::RSP_NONE;
                     end
                  end
                  usdrh_pkg::REQ_SET_ADDRESS: begin
                     if ((req.w_index == 16'd0) && (req.w_length == 16'd0) &&
                         (ctx.state != usdrh_pkg::DEV_CONFIGURED)) begin
                        ctx_next.address = req.w_value[6:0];
                        ctx_next.state   = (req.w_value[6:0] != 7'd0) ?
                                           usdrh_pkg::DEV_ADDRESSED :
                                           usdrh_pkg::DEV_DEFAULT;
                        rsp.response     = usdrh_pkg::RSP_ACK;
                     end
                  end
                  usdrh_pkg::REQ_GET_DESCRIPTOR: begin
                     if (desc_ok) begin
                        if (req.w_length == 16'd0) begin
                           rsp.response = usdrh_pkg::RSP_NONE;
                        end else begin
                           rsp.reply_value  = req.w_value;
                           rsp.reply_length = req.w_length;
                           rsp.response     = usdrh_pkg::RSP_FETCH;
                        end
                     end
                  end
                  usdrh_pkg::REQ_GET_CONFIGURATION: begin
                     if ((req.w_length == 16'd1) && live) begin
                        rsp.reply_value  = {8'd0,
                           (ctx.state == usdrh_pkg::DEV_CONFIGURED) ? ctx.cfg : 8'd0};
                        rsp.reply_length = 16'd1;
                        rsp.response     = usdrh_pkg::RSP_DATA;
                     end
                  end
                  usdrh_pkg::REQ_SET_CONFIGURATION: begin
                     if (idx <= max_configurations) begin
                        if (ctx.state == usdrh_pkg::DEV_ADDRESSED) begin
                           if (idx != 8'd0) begin
                              ctx_next.cfg     = idx;
                              ctx_next.state   = usdrh_pkg::DEV_CONFIGURED;
                              rsp.class_action = usdrh_pkg::CLS_SET;
                              rsp.class_config = idx;
                           end
                           rsp.response = usdrh_pkg::RSP_ACK;
                        end else if (ctx.state == usdrh_pkg::DEV_CONFIGURED) begin
                           if (idx == 8'd0) begin
                              rsp.class_action = usdrh_pkg::CLS_CLEAR;
                              rsp.class_config = ctx.cfg;
                              ctx_next.cfg     = 8'd0;
                              ctx_next.state   = usdrh_pkg::DEV_ADDRESSED;
                           end else if (idx != ctx.cfg) begin
                              rsp.class_action = usdrh_pkg::CLS_CLEAR_SET;
                              rsp.class_config = idx;
                              ctx_next.cfg     = idx;
                           end
                           rsp.response = usdrh_pkg::RSP_ACK;
                        end
                     end
                  end
                  default: begin
                     rsp.response = usdrh_pkg::RSP_STALL;
                  end
               endcase
            end
            usdrh_pkg::RCP_INTERFACE: begin
               rsp.response = usdrh_pkg::RSP_ITF;
            end
            usdrh_pkg::RCP_ENDPOINT: begin
               rsp.response = usdrh_pkg::RSP_EP;
            end
            default: begin
               rsp.response = usdrh_pkg::RSP_STALL;
            end
         endcase
      end

      rsp.device_address = ctx_next.address;
      rsp.device_state   = ctx_next.state;
   end

endmodule
`default_nettype wire

// ===== design/usb_std_device_request_handler_unit.sv =====
`default_nettype none
// A result is offered on the rsp side once its item has moved from the input register into the result register.
// One item per cycle unless the result side stalls; the decode sits between the input and result registers.
// The device context is updated as each item moves into the result register, so the
// next item always sees the state left by the one before it.
// Reset (synchronous, active high): default state, address 0, configuration 0,
// wakeup disabled, max_configurations 1, self_powered 0, both stages empty.
// -----------------------------------------------------------------------------
// USB standard device request handler - top level
// Input register, request decoder, result register and the device context.
// -----------------------------------------------------------------------------
module usb_std_device_request_handler_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // bm_request [7:0], b_request [15:8], w_value [31:16], w_index [47:32],
   // w_length [63:48]
   input  wire logic [63:0] req_tdata,
   // func [0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // reply_value [15:0], reply_length [31:16], class_action [33:32],
   // class_config [41:34], device_address [48:42], device_state [50:49], zeros above
   output logic [55:0]      rsp_tdata,
   // response [2:0]
   output logic [2:0]       rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   logic                   in_vld_ff;
   logic                   in_vld_in;
   usdrh_pkg::req_item_type in_item_ff;
   logic                   out_vld_ff;
   logic                   out_vld_in;
   usdrh_pkg::rsp_item_type out_item_ff;
   usdrh_pkg::rsp_item_type dec_rsp;
   usdrh_pkg::dev_ctx_type  ctx_ff;
   usdrh_pkg::dev_ctx_type  ctx_in;
   usdrh_pkg::dev_ctx_type  ctx_next;
   logic [7:0]             max_cfg_ff;
   logic                   self_pwr_ff;
   logic                   adv;

   // The input stage moves on when the result register is empty or being emptied.
   assign adv        = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;
   assign in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
   assign out_vld_in = adv ? 1'b1 : (out_vld_ff && !rsp_tready);
   assign ctx_in     = adv ? ctx_next : ctx_ff;

   usdrh_decode u_decode (
      .req                (in_item_ff),
      .ctx                (ctx_ff),
      .max_configurations (max_cfg_ff),
      .self_powered       (self_pwr_ff),
      .rsp                (dec_rsp),
      .ctx_next           (ctx_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         out_vld_ff     <= 1'b0;
         ctx_ff.state   <= usdrh_pkg::DEV_DEFAULT;
         ctx_ff.address <= 7'd0;
         ctx_ff.cfg     <= 8'd0;
         ctx_ff.wakeup  <= 1'b0;
         max_cfg_ff     <= usdrh_pkg::MAX_CONFIGURATIONS_RESET;
         self_pwr_ff    <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         ctx_ff     <= ctx_in;
         if (csr_we) begin
            case (csr_index)
               usdrh_pkg::CSR_MAX_CONFIGURATIONS: max_cfg_ff  <= csr_wdata;
               usdrh_pkg::CSR_SELF_POWERED:       self_pwr_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.func       <= req_tuser;
         in_item_ff.bm_request <= req_tdata[7:0];
         in_item_ff.b_request  <= req_tdata[15:8];
         in_item_ff.w_value    <= req_tdata[31:16];
         in_item_ff.w_index    <= req_tdata[47:32];
         in_item_ff.w_length   <= req_tdata[63:48];
      end
      if (adv) begin
         out_item_ff <= dec_rsp;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_item_ff.response;
   assign rsp_tdata  = {5'd0,
                        out_item_ff.device_state,
                        out_item_ff.device_address,
                        out_item_ff.class_config,
                        out_item_ff.class_action,
                        out_item_ff.reply_length,
                        out_item_ff.reply_value};

`ifndef NO_ASSERTIONS
   // A configured device always holds a nonzero configuration index.
   a_cfg_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ctx_ff.state == usdrh_pkg::DEV_CONFIGURED) |-> (ctx_ff.cfg != 8'd0))
      else $error("configured state with configuration index zero");

   // Leaving the default state is only possible through a nonzero address.
   a_addr_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ctx_ff.state != usdrh_pkg::DEV_DEFAULT) |-> (ctx_ff.address != 7'd0))
      else $error("device out of default state with address zero");

   // The device context changes only when an item is passed to the result register.
   a_ctx_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(ctx_ff))
      else $error("device context changed without an item");

   // A class set request is only issued with an acknowledged request.
   a_set_ack: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_item_ff.class_action == usdrh_pkg::CLS_SET)) |->
      (out_item_ff.response == usdrh_pkg::RSP_ACK))
      else $error("class set without status acknowledge");
`endif

endmodule
`default_nettype wire

// ===== tb/usdrh_answer_checker.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Standard device request handler - answer checker
// Watches the request, result and register ports, keeps its own copy of the
// device context, predicts the answer to every accepted item and compares
// each returned item field by field with the oldest prediction.
// -----------------------------------------------------------------------------
module usdrh_answer_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [55:0] rsp_tdata,
   input  wire logic [2:0]  rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata,
   output int unsigned      answers_pending,
   output int unsigned      mismatch_count
);
   import usdrh_pkg::*;

   dev_state_code_type link_state;
   logic [6:0]         cur_address;
   logic [7:0]         cur_config;
   logic               wakeup_on;
   logic [7:0]         max_configs;
   logic               self_pwr;
   rsp_item_type       answers_due[$];

   // Works out the answer to one request and moves the device context on.
   function automatic rsp_item_type device_answer(input req_item_type rq);
      rsp_item_type r;
      logic         live;
      logic [7:0]   sel;
      logic         desc_ok;
      r = '0;
      r.response = RSP_STALL;
      live = (link_state == DEV_ADDRESSED) || (link_state == DEV_CONFIGURED);
      if (rq.func) begin
         // A disconnect keeps address and configuration but drops the state.
         link_state = DEV_DEFAULT;
         r.class_action = CLS_CLEAR;
         r.class_config = cur_config;
         r.response = RSP_NONE;
      end else begin
         case (rq.bm_request[4:0])
            RCP_INTERFACE: r.response = RSP_ITF;
            RCP_ENDPOINT:  r.response = RSP_EP;
            RCP_DEVICE: begin
               case (rq.b_request)
                  REQ_GET_STATUS: begin
                     if (live) begin
                        r.response = RSP_DATA;
                        r.reply_value = {14'd0, wakeup_on, self_pwr};
                        r.reply_length = 16'd2;
                     end
                  end
                  REQ_CLEAR_FEATURE: begin
                     if (live) begin
                        if (rq.w_value != FEATURE_REMOTE_WAKEUP) begin
                           r.response = RSP_NONE;
                        end else begin
                           wakeup_on = 1'b0;
                           r.response = RSP_ACK;
                        end
                     end
                  end
                  REQ_SET_FEATURE: begin
                     if (rq.w_value != FEATURE_REMOTE_WAKEUP) begin
                        r.response = RSP_NONE;
                     end else begin
                        wakeup_on = 1'b1;
                        r.response = RSP_ACK;
                     end
                  end
                  REQ_SET_ADDRESS: begin
                     if (rq.w_index == 16'd0 && rq.w_length == 16'd0 &&
                         link_state != DEV_CONFIGURED) begin
                        cur_address = rq.w_value[6:0];
                        link_state = (cur_address != 7'd0) ? DEV_ADDRESSED : DEV_DEFAULT;
                        r.response = RSP_ACK;
                     end
                  end
                  REQ_GET_DESCRIPTOR: begin
                     desc_ok = (rq.w_value[15:8] == DESC_DEVICE) ||
                               (rq.w_value[15:8] == DESC_CONFIGURATION) ||
                               (rq.w_value[15:8] == DESC_STRING &&
                                rq.w_value[7:0] <= DESC_STRING_MAX);
                     if (desc_ok) begin
                        if (rq.w_length == 16'd0) begin
                           r.response = RSP_NONE;
                        end else begin
                           r.response = RSP_FETCH;
                           r.reply_value = rq.w_value;
                           r.reply_length = rq.w_length;
                        end
                     end
                  end
                  REQ_GET_CONFIGURATION: begin
                     if (rq.w_length == 16'd1 && live) begin
                        r.response = RSP_DATA;
                        r.reply_value = (link_state == DEV_CONFIGURED) ?
                                        {8'd0, cur_config} : 16'd0;
                        r.reply_length = 16'd1;
                     end
                  end
                  REQ_SET_CONFIGURATION: begin
                     sel = rq.w_value[7:0];
                     if (sel <= max_configs && link_state == DEV_ADDRESSED) begin
                        if (sel != 8'd0) begin
                           cur_config = sel;
                           link_state = DEV_CONFIGURED;
                           r.class_action = CLS_SET;
                           r.class_config = sel;
                        end
                        r.response = RSP_ACK;
                     end else if (sel <= max_configs && link_state == DEV_CONFIGURED) begin
                        if (sel == 8'd0) begin
                           r.class_action = CLS_CLEAR;
                           r.class_config = cur_config;
                           cur_config = 8'd0;
                           link_state = DEV_ADDRESSED;
                        end else if (sel != cur_config) begin
                           r.class_action = CLS_CLEAR_SET;
                           r.class_config = sel;
                           cur_config = sel;
                        end
                        r.response = RSP_ACK;
                     end
                  end
                  default: r.response = RSP_STALL;
               endcase
            end
            default: r.response = RSP_STALL;
         endcase
      end
      r.device_address = cur_address;
      r.device_state = link_state;
      return r;
   endfunction

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      req_item_type rq;
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         link_state = DEV_DEFAULT;
         cur_address = 7'd0;
         cur_config = 8'd0;
         wakeup_on = 1'b0;
         max_configs = MAX_CONFIGURATIONS_RESET;
         self_pwr = 1'b0;
         answers_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MAX_CONFIGURATIONS) begin
               max_configs = csr_wdata;
            end else begin
               self_pwr = csr_wdata[0];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.response = rsp_code_type'(rsp_tuser);
            got.reply_value = rsp_tdata[15:0];
            got.reply_length = rsp_tdata[31:16];
            got.class_action = class_act_type'(rsp_tdata[33:32]);
            got.class_config = rsp_tdata[41:34];
            got.device_address = rsp_tdata[48:42];
            got.device_state = dev_state_code_type'(rsp_tdata[50:49]);
            if (answers_due.size() == 0) begin
               $display("%0t: result item with none expected, response %0d, data 0x%0h",
                        $time, rsp_tuser, rsp_tdata);
               mismatch_count++;
            end else begin
               want = answers_due.pop_front();
               check_field("response", 32'(want.response), 32'(got.response));
               check_field("reply_value", 32'(want.reply_value), 32'(got.reply_value));
               check_field("reply_length", 32'(want.reply_length), 32'(got.reply_length));
               check_field("class_action", 32'(want.class_action), 32'(got.class_action));
               check_field("class_config", 32'(want.class_config), 32'(got.class_config));
               check_field("device_address", 32'(want.device_address),
                           32'(got.device_address));
               check_field("device_state", 32'(want.device_state), 32'(got.device_state));
               check_field("tdata padding", 32'd0, 32'(rsp_tdata[55:51]));
            end
         end
         if (req_tvalid && req_tready) begin
            rq.func = req_tuser;
            rq.bm_request = req_tdata[7:0];
            rq.b_request = req_tdata[15:8];
            rq.w_value = req_tdata[31:16];
            rq.w_index = req_tdata[47:32];
            rq.w_length = req_tdata[63:48];
            answers_due.push_back(device_answer(rq));
         end
      end
      answers_pending <= answers_due.size();
   end

endmodule

// ===== tb/tb_usb_std_device_request_handler_unit.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Standard device request handler - testbench top
// Drives directed and random setup packets and disconnects through the
// request handler under several register settings, with random gaps and
// stalls on both sides, and reports the checker's verdict.
// -----------------------------------------------------------------------------
module tb_usb_std_device_request_handler_unit;
   import usdrh_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned ITEMS_PER_PHASE = 425;
   localparam int unsigned HOLD_CYCLES     = 250;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   int unsigned answers_pending;
   int unsigned mismatch_count;
   int unsigned cycle_count;
   bit          idle_on;
   bit          sink_hold;
   logic [7:0]  cur_max;

   usb_std_device_request_handler_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   usdrh_answer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .answers_pending (answers_pending),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic req_item_type make_request(input logic func, input logic [7:0] bm,
                                                 input logic [7:0] br,
                                                 input logic [15:0] wv,
                                                 input logic [15:0] wi,
                                                 input logic [15:0] wl);
      req_item_type rq;
      rq.func = func;
      rq.bm_request = bm;
      rq.b_request = br;
      rq.w_value = wv;
      rq.w_index = wi;
      rq.w_length = wl;
      return rq;
   endfunction

   // Mostly well-formed device requests with random content, the rest noise,
   // disconnects and requests for other recipients.
   function automatic req_item_type random_request();
      req_item_type rq;
      int unsigned  pick;
      rq.func = 1'b0;
      rq.bm_request = 8'($urandom);
      rq.b_request = 8'($urandom);
      rq.w_value = 16'($urandom);
      rq.w_index = 16'($urandom);
      rq.w_length = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         rq.func = 1'b1;
      end else if (pick < 12) begin
         rq.func = 1'b0;
      end else if (pick < 22) begin
         rq.bm_request[4:0] = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(3, 31)) :
                                                            5'($urandom_range(1, 2));
      end else begin
         rq.bm_request[4:0] = RCP_DEVICE;
         case ($urandom_range(0, 7))
            0: rq.b_request = REQ_GET_STATUS;
            1: begin
               rq.b_request = REQ_CLEAR_FEATURE;
               if ($urandom_range(0, 3) != 0) rq.w_value = FEATURE_REMOTE_WAKEUP;
            end
            2: begin
               rq.b_request = REQ_SET_FEATURE;
               if ($urandom_range(0, 3) != 0) rq.w_value = FEATURE_REMOTE_WAKEUP;
            end
            3: begin
               rq.b_request = REQ_SET_ADDRESS;
               if ($urandom_range(0, 3) != 0) begin
                  rq.w_index = 16'd0;
                  rq.w_length = 16'd0;
               end
               if ($urandom_range(0, 7) == 0) rq.w_value[6:0] = 7'd0;
            end
            4: begin
               rq.b_request = REQ_GET_DESCRIPTOR;
               rq.w_value[15:8] = 8'($urandom_range(0, 8));
               if ($urandom_range(0, 3) != 0) rq.w_value[7:0] = 8'($urandom_range(0, 7));
               if ($urandom_range(0, 7) == 0) rq.w_length = 16'd0;
            end
            5: begin
               rq.b_request = REQ_GET_CONFIGURATION;
               if ($urandom_range(0, 3) != 0) rq.w_length = 16'd1;
            end
            6: begin
               rq.b_request = REQ_SET_CONFIGURATION;
               if ($urandom_range(0, 3) != 0)
                  rq.w_value[7:0] = 8'($urandom_range(0, int'(cur_max) + 1));
            end
            default: rq.b_request = 8'($urandom);
         endcase
      end
      return rq;
   endfunction

   task automatic offer(input req_item_type rq);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rq.w_length, rq.w_index, rq.w_value, rq.b_request, rq.bm_request};
      req_tuser <= rq.func;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering items until every predicted answer has been returned.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (answers_pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned n;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = 8'd0;
      idle_on = 1'b1;
      sink_hold = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      cur_max = 8'd1;
      write_csr(CSR_MAX_CONFIGURATIONS, cur_max);
      write_csr(CSR_SELF_POWERED, 8'd0);

      offer(make_request(1'b0, 8'h80, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
      offer(make_request(1'b0, 8'h00, REQ_SET_CONFIGURATION, 16'd1, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h00, REQ_SET_ADDRESS, 16'd5, 16'd1, 16'd0));
      offer(make_request(1'b0, 8'h00, REQ_SET_ADDRESS, 16'hFFFF, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h80, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
      offer(make_request(1'b0, 8'h00, REQ_SET_FEATURE, FEATURE_REMOTE_WAKEUP, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h00, REQ_SET_FEATURE, 16'd2, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h80, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
      offer(make_request(1'b0, 8'h00, REQ_CLEAR_FEATURE, 16'd0, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h00, REQ_CLEAR_FEATURE, FEATURE_REMOTE_WAKEUP, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h80, REQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd2));
      offer(make_request(1'b0, 8'h80, REQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd1));
      offer(make_request(1'b0, 8'h00, REQ_SET_CONFIGURATION, 16'd2, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h00, REQ_SET_CONFIGURATION, 16'hFF01, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h80, REQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd1));
      offer(make_request(1'b0, 8'h00, REQ_SET_ADDRESS, 16'd3, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h00, REQ_SET_CONFIGURATION, 16'd0, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h80, REQ_GET_DESCRIPTOR, 16'h0100, 16'd0, 16'hFFFF));
      offer(make_request(1'b0, 8'h80, REQ_GET_DESCRIPTOR, 16'h0200, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h80, REQ_GET_DESCRIPTOR, 16'h0305, 16'h0409, 16'h0040));
      offer(make_request(1'b0, 8'h80, REQ_GET_DESCRIPTOR, 16'h0306, 16'd0, 16'h0040));
      offer(make_request(1'b0, 8'h80, REQ_GET_DESCRIPTOR, 16'h0600, 16'd0, 16'h000A));
      offer(make_request(1'b0, 8'h81, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      offer(make_request(1'b0, 8'h02, REQ_SET_FEATURE, 16'd0, 16'h0081, 16'd0));
      offer(make_request(1'b0, 8'hFF, REQ_GET_STATUS, 16'd0, 16'd0, 16'd2));
      offer(make_request(1'b0, 8'h00, 8'hFF, 16'd0, 16'd0, 16'd0));
      offer(make_request(1'b1, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0));
      offer(make_request(1'b0, 8'h00, REQ_SET_ADDRESS, 16'd0, 16'd0, 16'd0));
      settle();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               cur_max = 8'd255;
               write_csr(CSR_SELF_POWERED, 8'd1);
            end
            1: begin
               cur_max = 8'd1;
               write_csr(CSR_SELF_POWERED, 8'd0);
            end
            2: begin
               cur_max = 8'd3;
               write_csr(CSR_SELF_POWERED, 8'd1);
            end
            default: begin
               cur_max = 8'($urandom_range(1, 255));
               write_csr(CSR_SELF_POWERED, 8'($urandom_range(0, 1)));
            end
         endcase
         write_csr(CSR_MAX_CONFIGURATIONS, cur_max);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 100 == 0) idle_on = 1'($urandom);
            // The result side holds off for a long stretch while items keep coming.
            if (phase == 1 && n == 150) sink_hold = 1'b1;
            if (phase == 2 && n == 200) settle();
            offer(random_request());
         end
         settle();
      end

      if (mismatch_count == 0) begin
         $display("usb_std_device_request_handler_unit verification clean");
      end else begin
         $display("usb_std_device_request_handler_unit verification failed");
      end
      $finish;
   end

   initial begin : result_sink
      int unsigned gap;
      rsp_tready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = sink_hold ? HOLD_CYCLES : (idle_on ? $urandom_range(0, 19) : 0);
         sink_hold = 1'b0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("usb_std_device_request_handler_unit verification failed");
      $finish;
   end

endmodule

// ===== usb_std_device_request_handler_unit.f =====
design/usdrh_pkg.sv
design/usdrh_decode.sv
design/usb_std_device_request_handler_unit.sv
tb/usdrh_answer_checker.sv
tb/tb_usb_std_device_request_handler_unit.sv
